FILE: hw/rtl/rast_pkg.sv
// Package for the range-add / range-sum tree block.
// Holds command codes and fixed field widths; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rast_pkg;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_ADD   = 2'd3
  } cmd_t;
endpackage
`default_nettype wire

FILE: hw/rtl/rast_if.sv
// Valid/ready channel interfaces for the command and result transfers.
// Depends on rast_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rast_in_if import rast_pkg::*; ();
  logic                     valid;
  logic                     ready;
  cmd_t                     command;
  logic [IDX_W-1:0]         low_index;
  logic [IDX_W-1:0]         high_index;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, command, low_index, high_index, value, input ready);
  modport sink   (input valid, command, low_index, high_index, value, output ready);
endinterface

interface rast_out_if import rast_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] range_sum;
  cmd_t                     done_kind;

  modport source (output valid, range_sum, done_kind, input ready);
  modport sink   (input valid, range_sum, done_kind, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/range_add_range_sum_tree.sv
// Top level of the range-add / range-sum lazy segment tree.
// Depends on rast_pkg, rast_if (channel interfaces) and rast_ram.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps a lazy segment tree over up to MAX_ELEMENTS signed 32-bit
// elements, of which cfg_data sets how many are in use (a value of zero acts
// as one, a value above MAX_ELEMENTS as MAX_ELEMENTS). Every command transfer
// produces exactly one result transfer that echoes the command; only a query
// carries a nonzero sum. After reset the block clears all NODE_SLOTS entries of
// the node sum and pending add memories and accepts no command
// meanwhile; configuration writes are taken at any time but must only be made
// while the block is idle. One command is worked on at a time, and the input
// is not ready until its result has been placed in the output register. A
// load writes its element when it is taken. A build clears the pending adds and
// then walks every node once. A query or range add walks the tree depth first
// with an explicit ancestor stack; at each visited node the node sum, the
// node's pending add and both children's pending adds are each read and
// written one after another through the single read port of one memory per
// kind, and a range add also refolds the child sums of each inner node it leaves.
// A typical range touches about four nodes per level. Node sums wrap modulo
// 2^32. Elements that were never loaded must not be built over.
module range_add_range_sum_tree import rast_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int NODE_SLOTS   = 4096
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             cfg_we,
  input wire logic [CNT_W-1:0] cfg_data,
  rast_in_if.sink              in_ch,
  rast_out_if.source           out_ch
);
  localparam int EW = $clog2(MAX_ELEMENTS);   // element index width
  localparam int NW = EW + 3;                 // heap node index width
  localparam int AW = $clog2(NODE_SLOTS);     // node memory address width
  localparam int SD = EW;                     // ancestor stack depth
  localparam int IW = (SD > 1) ? $clog2(SD) : 1;
  localparam int PW = $clog2(SD + 1);
  localparam int LW = EW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BCLR, S_VISIT, S_PRD, S_SRD, S_WSUM, S_C1,
    S_C2, S_PZ, S_POP, S_CMB1, S_CMB2, S_CMB3, S_ELW, S_DONE
  } state_t;

  // One ancestor frame: the node, its element span, and which child is active.
  typedef struct packed {
    logic [NW-1:0] node;
    logic [EW-1:0] a;
    logic [EW-1:0] b;
    logic          right;
  } frame_t;

  state_t              state_r;
  logic [AW-1:0]       clr_r;
  logic [CNT_W-1:0]    count_r;
  cmd_t                cmd_r;
  logic [IDX_W-1:0]    lo_r, hi_r;
  logic [DATA_W-1:0]   val_r, acc_r, d_r, s_r, prod_r;
  logic [NW-1:0]       cur_node_r;
  logic [EW-1:0]       cur_a_r, cur_b_r;
  logic [PW-1:0]       sp_r;
  frame_t              stack_r [SD];
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_sum_r;
  cmd_t                out_kind_r;

  function automatic logic node_ok(input logic [NW-1:0] x);
    return 32'(x) < 32'(NODE_SLOTS);
  endfunction

  // Span of the tree from the configured element count.
  logic [31:0]   span;
  logic [EW-1:0] last_idx;
  always_comb begin
    if (count_r == '0) begin
      span = 32'd1;
    end else if (32'(count_r) > 32'(MAX_ELEMENTS)) begin
      span = 32'(MAX_ELEMENTS);
    end else begin
      span = 32'(count_r);
    end
    last_idx = EW'(span - 32'd1);
  end

  // Geometry of the current node and of the frame on top of the stack.
  logic [EW-1:0] mid, top_mid;
  logic [NW-1:0] c1, c2, top_c2;
  logic [LW-1:0] len;
  logic          out_rng, cov;
  frame_t        top;
  logic [IW-1:0] top_idx;

  assign mid     = cur_a_r + ((cur_b_r - cur_a_r) >> 1);
  assign c1      = (cur_node_r << 1) + NW'(1);
  assign c2      = (cur_node_r << 1) + NW'(2);
  assign len     = LW'(cur_b_r - cur_a_r) + LW'(1);
  assign out_rng = (32'(lo_r) > 32'(cur_b_r)) || (32'(hi_r) < 32'(cur_a_r));
  assign cov     = (32'(lo_r) <= 32'(cur_a_r)) && (32'(hi_r) >= 32'(cur_b_r));
  assign top_idx = IW'(sp_r - PW'(1));
  assign top     = stack_r[top_idx];
  assign top_mid = top.a + ((top.b - top.a) >> 1);
  assign top_c2  = (top.node << 1) + NW'(2);

  // Memories.
  logic              sum_we, pend_we, el_we;
  logic [AW-1:0]     sum_wa, sum_ra, pend_wa, pend_ra;
  logic [DATA_W-1:0] sum_wd, sum_q, pend_wd, pend_q, el_q;
  logic [EW-1:0]     el_wa, el_ra;

  rast_ram #(.WIDTH(DATA_W), .DEPTH(NODE_SLOTS)) u_sum_ram (
    .clk(clk), .we(sum_we), .waddr(sum_wa), .wdata(sum_wd), .raddr(sum_ra), .rdata(sum_q)
  );
  rast_ram #(.WIDTH(DATA_W), .DEPTH(NODE_SLOTS)) u_pend_ram (
    .clk(clk), .we(pend_we), .waddr(pend_wa), .wdata(pend_wd), .raddr(pend_ra),
    .rdata(pend_q)
  );
  rast_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
    .clk(clk), .we(el_we), .waddr(el_wa), .wdata(in_ch.value), .raddr(el_ra), .rdata(el_q)
  );

  logic [DATA_W-1:0] pend_m, sum_m;
  assign pend_m = node_ok(cur_node_r) ? pend_q : '0;
  assign sum_m  = node_ok(cur_node_r) ? sum_q : '0;

  always_comb begin
    sum_we  = 1'b0;
    sum_wa  = AW'(cur_node_r);
    sum_wd  = '0;
    sum_ra  = AW'(cur_node_r);
    pend_we = 1'b0;
    pend_wa = AW'(cur_node_r);
    pend_wd = '0;
    pend_ra = AW'(cur_node_r);
    el_we   = 1'b0;
    el_wa   = EW'(in_ch.low_index);
    el_ra   = cur_a_r;
    unique case (state_r)
      S_CLEAR: begin
        sum_we  = 1'b1;
        sum_wa  = clr_r;
        pend_we = 1'b1;
        pend_wa = clr_r;
      end
      S_BCLR: begin
        pend_we = 1'b1;
        pend_wa = clr_r;
      end
      S_IDLE: begin
        el_we = in_ch.valid && (in_ch.command == CMD_LOAD)
                && (32'(in_ch.low_index) < 32'(MAX_ELEMENTS));
      end
      S_WSUM: begin
        sum_we  = node_ok(cur_node_r);
        sum_wd  = s_r + prod_r;
        pend_ra = AW'(c1);
      end
      S_C1: begin
        pend_we = node_ok(c1);
        pend_wa = AW'(c1);
        pend_wd = pend_q + d_r;
        pend_ra = AW'(c2);
      end
      S_C2: begin
        pend_we = node_ok(c2);
        pend_wa = AW'(c2);
        pend_wd = pend_q + d_r;
      end
      S_PZ: begin
        pend_we = node_ok(cur_node_r);
      end
      S_CMB1: sum_ra = AW'(c1);
      S_CMB2: sum_ra = AW'(c2);
      S_CMB3: begin
        sum_we = node_ok(cur_node_r);
        sum_wd = s_r + (node_ok(c2) ? sum_q : '0);
      end
      S_ELW: begin
        sum_we = node_ok(cur_node_r);
        sum_wd = el_q;
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.range_sum = out_sum_r;
  assign out_ch.done_kind = out_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      sp_r        <= '0;
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_data;
      end
      // In S_DONE the output register is refilled below instead.
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(NODE_SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r      <= in_ch.command;
            lo_r       <= in_ch.low_index;
            hi_r       <= in_ch.high_index;
            val_r      <= in_ch.value;
            acc_r      <= '0;
            sp_r       <= '0;
            cur_node_r <= '0;
            cur_a_r    <= '0;
            cur_b_r    <= last_idx;
            clr_r      <= '0;
            unique case (in_ch.command)
              CMD_LOAD:  state_r <= S_DONE;
              CMD_BUILD: state_r <= S_BCLR;
              default: begin
                state_r <= (in_ch.low_index <= in_ch.high_index) ? S_VISIT : S_DONE;
              end
            endcase
          end
        end
        S_BCLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(NODE_SLOTS - 1)) begin
            state_r <= S_VISIT;
          end
        end
        S_VISIT: begin
          if (cmd_r == CMD_BUILD) begin
            if (cur_a_r == cur_b_r) begin
              state_r <= S_ELW;
            end else begin
              stack_r[IW'(sp_r)] <= '{node: cur_node_r, a: cur_a_r, b: cur_b_r, right: 1'b0};
              sp_r       <= sp_r + PW'(1);
              cur_node_r <= c1;
              cur_b_r    <= mid;
            end
          end else if ((cmd_r == CMD_QUERY) && out_rng) begin
            state_r <= S_POP;
          end else begin
            state_r <= S_PRD;
          end
        end
        S_PRD: begin
          // The pending add folds with the new amount when an add covers the node.
          d_r     <= pend_m + (((cmd_r == CMD_ADD) && cov) ? val_r : '0);
          state_r <= S_SRD;
        end
        S_SRD: begin
          s_r     <= sum_m;
          prod_r  <= 32'(d_r * len);
          state_r <= S_WSUM;
        end
        S_WSUM: begin
          s_r     <= s_r + prod_r;
          state_r <= (cur_a_r != cur_b_r) ? S_C1 : S_PZ;
        end
        S_C1: state_r <= S_C2;
        S_C2: state_r <= S_PZ;
        S_PZ: begin
          if (cmd_r == CMD_QUERY && cov) begin
            acc_r   <= acc_r + s_r;
            state_r <= S_POP;
          end else if (cmd_r == CMD_ADD && (out_rng || cov)) begin
            state_r <= S_POP;
          end else begin
            stack_r[IW'(sp_r)] <= '{node: cur_node_r, a: cur_a_r, b: cur_b_r, right: 1'b0};
            sp_r       <= sp_r + PW'(1);
            cur_node_r <= c1;
            cur_b_r    <= mid;
            state_r    <= S_VISIT;
          end
        end
        S_POP: begin
          if (sp_r == '0) begin
            state_r <= S_DONE;
          end else if (!top.right) begin
            stack_r[top_idx] <= '{node: top.node, a: top.a, b: top.b, right: 1'b1};
            cur_node_r <= top_c2;
            cur_a_r    <= top_mid + EW'(1);
            cur_b_r    <= top.b;
            state_r    <= S_VISIT;
          end else begin
            cur_node_r <= top.node;
            cur_a_r    <= top.a;
            cur_b_r    <= top.b;
            sp_r       <= sp_r - PW'(1);
            if (cmd_r != CMD_QUERY) begin
              state_r <= S_CMB1;
            end
          end
        end
        S_CMB1: state_r <= S_CMB2;
        S_CMB2: begin
          s_r     <= node_ok(c1) ? sum_q : '0;
          state_r <= S_CMB3;
        end
        S_CMB3: state_r <= S_POP;
        S_ELW:  state_r <= S_POP;
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_sum_r   <= (cmd_r == CMD_QUERY) ? acc_r : '0;
            out_kind_r  <= cmd_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rast_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rast_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: tb/tb_range_add_range_sum_tree.sv
// Self-checking testbench for the range-add / range-sum lazy segment tree.
// Depends on rast_pkg, rast_if and the range_add_range_sum_tree top level.
`timescale 1ns / 1ps
module tb_range_add_range_sum_tree;
  import rast_pkg::*;

  localparam int MAX_EL = 1024;
  localparam int SLOTS = 4096;
  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;

  rast_in_if in_ch ();
  rast_out_if out_ch ();

  range_add_range_sum_tree dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #2 clk = ~clk;

  // Predictor state: a private copy of the tree, the element array and the count.
  logic [DATA_W-1:0] elem_mirror [MAX_EL];
  logic [DATA_W-1:0] sum_mirror [SLOTS];
  logic [DATA_W-1:0] lazy_mirror [SLOTS];
  bit loaded [MAX_EL];
  int unsigned span_cfg = 1;

  typedef struct packed {
    logic [DATA_W-1:0] range_sum;
    cmd_t kind;
  } result_t;
  result_t pending_results[$];

  int errors = 0;
  int sent = 0;
  int received = 0;
  int queries_seen = 0;
  longint cycle_count = 0;

  function automatic logic [DATA_W-1:0] node_rd(int unsigned n);
    return n < SLOTS ? sum_mirror[n] : '0;
  endfunction
  function automatic logic [DATA_W-1:0] lazy_rd(int unsigned n);
    return n < SLOTS ? lazy_mirror[n] : '0;
  endfunction
  function automatic void node_wr(int unsigned n, logic [DATA_W-1:0] v);
    if (n < SLOTS) sum_mirror[n] = v;
  endfunction
  function automatic void lazy_wr(int unsigned n, logic [DATA_W-1:0] v);
    if (n < SLOTS) lazy_mirror[n] = v;
  endfunction

  function automatic int unsigned active_span();
    if (span_cfg == 0) return 1;
    if (span_cfg > MAX_EL) return MAX_EL;
    return span_cfg;
  endfunction

  function automatic logic [DATA_W-1:0] build_sum(int unsigned n, int unsigned a,
                                                   int unsigned b);
    logic [DATA_W-1:0] s;
    int unsigned m;
    if (a == b) begin
      s = elem_mirror[a];
    end else begin
      m = a + (b - a) / 2;
      s = build_sum(2*n+1, a, m) + build_sum(2*n+2, m+1, b);
    end
    node_wr(n, s);
    return s;
  endfunction

  // Fold a node's pending add into its sum and hand it down to the children.
  function automatic void settle(int unsigned n, int unsigned a, int unsigned b);
    logic [DATA_W-1:0] p;
    p = lazy_rd(n);
    if (p == 0) return;
    node_wr(n, node_rd(n) + p * (b - a + 1));
    if (a != b) begin
      lazy_wr(2*n+1, lazy_rd(2*n+1) + p);
      lazy_wr(2*n+2, lazy_rd(2*n+2) + p);
    end
    lazy_wr(n, '0);
  endfunction

  function automatic logic [DATA_W-1:0] range_total(int unsigned n, int unsigned a,
      int unsigned b, int unsigned lo, int unsigned hi);
    int unsigned m;
    if (lo > b || hi < a) return '0;
    settle(n, a, b);
    if (lo <= a && hi >= b) return node_rd(n);
    m = a + (b - a) / 2;
    return range_total(2*n+1, a, m, lo, hi) + range_total(2*n+2, m+1, b, lo, hi);
  endfunction

  function automatic void range_bump(int unsigned n, int unsigned a, int unsigned b,
      int unsigned lo, int unsigned hi, logic [DATA_W-1:0] x);
    int unsigned m;
    settle(n, a, b);
    if (lo > b || hi < a) return;
    if (lo <= a && hi >= b) begin
      node_wr(n, node_rd(n) + x * (b - a + 1));
      if (a != b) begin
        lazy_wr(2*n+1, lazy_rd(2*n+1) + x);
        lazy_wr(2*n+2, lazy_rd(2*n+2) + x);
      end
      return;
    end
    m = a + (b - a) / 2;
    range_bump(2*n+1, a, m, lo, hi, x);
    range_bump(2*n+2, m+1, b, lo, hi, x);
    node_wr(n, node_rd(2*n+1) + node_rd(2*n+2));
  endfunction

  // Apply one command to the mirror and queue the result the block must return.
  function automatic void predict(cmd_t c, int unsigned lo, int unsigned hi,
                                  logic [DATA_W-1:0] v);
    result_t r;
    int unsigned n;
    n = active_span();
    r.range_sum = '0;
    r.kind = c;
    case (c)
      CMD_LOAD: begin
        elem_mirror[lo] = v;
        loaded[lo] = 1'b1;
      end
      CMD_BUILD: begin
        foreach (lazy_mirror[i]) lazy_mirror[i] = '0;
        void'(build_sum(0, 0, n - 1));
      end
      CMD_QUERY: begin
        if (lo <= hi) r.range_sum = range_total(0, 0, n - 1, lo, hi);
      end
      default: begin
        if (lo <= hi) range_bump(0, 0, n - 1, lo, hi, v);
      end
    endcase
    pending_results.push_back(r);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  bit hold_gaps = 1'b0;

  // Drives one command and returns once the block has taken the transfer.
  // Valid stays up after the transfer until the next command or drain()
  // takes it down, so the next command can follow directly.
  task automatic send_cmd(cmd_t c, int unsigned lo, int unsigned hi,
                          logic [DATA_W-1:0] v);
    int unsigned g;
    g = hold_gaps ? 0 : gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= c;
    in_ch.low_index <= lo[IDX_W-1:0];
    in_ch.high_index <= hi[IDX_W-1:0];
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    predict(c, lo, hi, v);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Changes the element count while idle; every element in span is loaded
  // before any build so that no unwritten element is ever read.
  task automatic set_span(int unsigned c);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= c[CNT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    span_cfg = c;
  endtask

  task automatic load_span(bit full);
    int unsigned n;
    n = active_span();
    for (int unsigned i = 0; i < n; i++)
      if (full || !loaded[i]) send_cmd(CMD_LOAD, i, 0, rand_value());
  endtask

  task automatic test_directed();
    set_span(4);
    send_cmd(CMD_LOAD, 0, 0, 32'h7FFF_FFFF);
    send_cmd(CMD_LOAD, 1, 0, 32'h8000_0000);
    send_cmd(CMD_LOAD, 2, 0, 32'hFFFF_FFFF);
    send_cmd(CMD_LOAD, 3, 0, 32'h0000_0001);
    send_cmd(CMD_LOAD, 1023, 0, 32'h5555_AAAA);
    send_cmd(CMD_BUILD, 0, 0, 0);
    send_cmd(CMD_QUERY, 0, 3, 0);
    send_cmd(CMD_QUERY, 3, 1, 0);               // empty range
    send_cmd(CMD_QUERY, 2, 1023, 0);            // runs past the span
    send_cmd(CMD_ADD, 1, 2, 32'h7FFF_FFFF);
    send_cmd(CMD_ADD, 2, 0, 32'd5);             // empty add changes nothing
    send_cmd(CMD_ADD, 0, 1023, 32'h8000_0000);
    send_cmd(CMD_QUERY, 1, 1, 0);
    send_cmd(CMD_QUERY, 0, 3, 0);
    send_cmd(CMD_LOAD, 0, 0, 32'd9);            // load after build stays out of tree
    send_cmd(CMD_QUERY, 0, 0, 0);
    set_span(2);                                // count shrinks over built nodes
    send_cmd(CMD_QUERY, 0, 1, 0);
    send_cmd(CMD_ADD, 1, 1, 32'hFFFF_FFFF);
    send_cmd(CMD_QUERY, 0, 1023, 0);
    send_cmd(CMD_BUILD, 0, 0, 0);
    send_cmd(CMD_QUERY, 0, 1, 0);
  endtask

  task automatic test_count_extremes();
    set_span(0);                                // zero acts as one
    send_cmd(CMD_BUILD, 0, 0, 0);
    send_cmd(CMD_ADD, 0, 0, 32'd3);
    send_cmd(CMD_QUERY, 0, 1023, 0);
    set_span(2047);                             // clamps to the maximum
    load_span(1'b1);
    send_cmd(CMD_BUILD, 0, 0, 0);
    send_cmd(CMD_ADD, 0, 1023, 32'h1234_5678);
    send_cmd(CMD_QUERY, 0, 1023, 0);
    send_cmd(CMD_QUERY, 1023, 1023, 0);
    send_cmd(CMD_ADD, 512, 700, 32'h8000_0001);
    send_cmd(CMD_QUERY, 600, 1023, 0);
    set_span(1024);
    send_cmd(CMD_QUERY, 0, 511, 0);
  endtask

  // Random phases: mostly adds and queries over small spans, a few large.
  task automatic test_random(int unsigned items);
    int unsigned n, lo, hi, sel, k, base;
    bit held;
    base = sent;
    k = 0;
    held = 1'b0;
    while (k < items) begin
      sel = $urandom_range(0, 9);
      n = (sel == 0) ? $urandom_range(512, 1024) : $urandom_range(1, 40);
      set_span(n);
      load_span(1'b0);
      send_cmd(CMD_BUILD, 0, 0, 0);
      repeat ($urandom_range(20, 60)) begin
        sel = $urandom_range(0, 99);
        lo = $urandom_range(0, (sel < 85) ? n : 1023);
        hi = $urandom_range(0, (sel < 85) ? n : 1023);
        if (sel < 70 && lo > hi) begin
          lo = lo ^ hi; hi = lo ^ hi; lo = lo ^ hi;
        end
        if ($urandom_range(0, 3) == 0) lo = $urandom_range(0, 1023);
        sel = $urandom_range(0, 99);
        if (sel < 40) send_cmd(CMD_QUERY, lo, hi, $urandom);
        else if (sel < 85) send_cmd(CMD_ADD, lo, hi, rand_value());
        else if (sel < 95) send_cmd(CMD_LOAD, $urandom_range(0, 1023), $urandom, rand_value());
        else send_cmd(CMD_BUILD, $urandom, $urandom, $urandom);
      end
      k = sent - base;
      // Once, the sender holds off until the block has returned everything.
      if (k > items / 2 && !held) begin
        held = 1'b1;
        hold_gaps = 1'b1;
        drain();
        send_cmd(CMD_QUERY, 0, 1023, 0);
        send_cmd(CMD_ADD, 0, 1023, 32'hFFFF_FFFF);
        hold_gaps = 1'b0;
        k = sent - base;
      end
    end
  endtask

  // Result checker: compare each transfer against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      received++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result sum=%h kind=%0d", $time,
                 out_ch.range_sum, out_ch.done_kind);
      end else begin
        want = pending_results.pop_front();
        if (want.kind == CMD_QUERY) queries_seen++;
        if (out_ch.range_sum !== want.range_sum || out_ch.done_kind !== want.kind) begin
          errors++;
          $display("%0t: mismatch expected sum=%h kind=%0d actual sum=%h kind=%0d",
                   $time, want.range_sum, want.kind, out_ch.range_sum, out_ch.done_kind);
        end
      end
    end
  end

  // The receiver stalls with the same short/long mix as the sender.
  initial begin
    int unsigned s;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      s = gap_len();
      if (s == 0) out_ch.ready <= 1'b1;
      else begin
        out_ch.ready <= 1'b0;
        repeat (s - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    foreach (elem_mirror[i]) begin
      elem_mirror[i] = '0;
      loaded[i] = 1'b0;
    end
    foreach (sum_mirror[i]) begin
      sum_mirror[i] = '0;
      lazy_mirror[i] = '0;
    end
    in_ch.valid = 1'b0;
    in_ch.command = CMD_LOAD;
    in_ch.low_index = '0;
    in_ch.high_index = '0;
    in_ch.value = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_count_extremes();
    test_random(900);
    drain();
    $display("Sent %0d commands and checked %0d results, %0d of them range sums,",
             sent, received, queries_seen);
    $display("over element counts from the clamped minimum to the full tree.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d errors", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/rast_pkg.sv
hw/rtl/rast_if.sv
hw/rtl/rast_ram.sv
hw/rtl/range_add_range_sum_tree.sv
tb/tb_range_add_range_sum_tree.sv
